// ===== design/dpwp_pkg.sv =====
// Shared types and constants for the depth pixel to world point pipeline.
// Used by dpwp_csr, dpwp_backproj, dpwp_xform and the top level.
package dpwp_pkg;

   // Field widths
   localparam int DEPTH_W   = 16;
   localparam int RECIP_W   = 32;
   localparam int PP_W      = 16;
   localparam int ROT_W     = 18;                 // Q2.16 rotation entry
   localparam int ROT_ROW_W = 3 * ROT_W;          // 54
   localparam int TRANS_W   = 21;                 // signed mm per axis
   localparam int SIZE_W    = 13;                 // image width / height
   localparam int WORLD_W   = 32;

   // Camera point, Q.8 mm; wide enough for COORD_BITS up to 14
   localparam int CAM_W     = 40;
   localparam int PROD_W    = ROT_W + CAM_W;      // rotation product
   localparam int ACC_W     = PROD_W + 3;         // three products plus offset
   localparam int WIDE_W    = ACC_W - 24;         // rounded world value

   // Register file
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_ROT_ROW0        = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ROT_ROW1        = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ROT_ROW2        = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_TRANSLATION_MM  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_FOCAL_RECIP     = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_PRINCIPAL_POINT = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd7;

   // Reset values: identity rotation, VGA frame
   localparam logic [ROT_ROW_W-1:0] ROT_ROW0_RST = 54'h1_0000;
   localparam logic [ROT_ROW_W-1:0] ROT_ROW1_RST = 54'h1_0000 << ROT_W;
   localparam logic [ROT_ROW_W-1:0] ROT_ROW2_RST = 54'h1_0000 << (2 * ROT_W);
   localparam logic [SIZE_W-1:0]    WIDTH_RST    = 13'd640;
   localparam logic [SIZE_W-1:0]    HEIGHT_RST   = 13'd480;

   typedef struct packed {
      logic [2:0][ROT_ROW_W-1:0] rot_row;
      logic [3*TRANS_W-1:0]      translation;
      logic [2*RECIP_W-1:0]      focal_recip;
      logic [2*PP_W-1:0]         principal_point;
      logic [SIZE_W-1:0]         image_width;
      logic [SIZE_W-1:0]         image_height;
   } cfg_type;

   typedef struct packed {
      logic signed [CAM_W-1:0] x;
      logic signed [CAM_W-1:0] y;
      logic signed [CAM_W-1:0] z;
      logic                    inb;
   } cam_point_type;

endpackage

// ===== design/dpwp_csr.sv =====
// Configuration register file behind an APB-style write/read port.
// Depends on dpwp_pkg for register codes, widths and reset values.
module dpwp_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [dpwp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [dpwp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [dpwp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output dpwp_pkg::cfg_type               cfg
);
   import dpwp_pkg::*;

   logic [2:0][ROT_ROW_W-1:0] rot_ff;
   logic [3*TRANS_W-1:0]      trans_ff;
   logic [2*RECIP_W-1:0]      recip_ff;
   logic [2*PP_W-1:0]         pp_ff;
   logic [SIZE_W-1:0]         width_ff;
   logic [SIZE_W-1:0]         height_ff;
   logic                      wr_en;
   logic [REG_IDX_W-1:0]      reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[CSR_ADDR_W-1:3];

   // Register writes, masked to field width
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= ROT_ROW0_RST;
         rot_ff[1] <= ROT_ROW1_RST;
         rot_ff[2] <= ROT_ROW2_RST;
         trans_ff  <= '0;
         recip_ff  <= '0;
         pp_ff     <= '0;
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_ROT_ROW0:        rot_ff[0] <= pwdata[ROT_ROW_W-1:0];
            REG_ROT_ROW1:        rot_ff[1] <= pwdata[ROT_ROW_W-1:0];
            REG_ROT_ROW2:        rot_ff[2] <= pwdata[ROT_ROW_W-1:0];
            REG_TRANSLATION_MM:  trans_ff  <= pwdata[3*TRANS_W-1:0];
            REG_FOCAL_RECIP:     recip_ff  <= pwdata[2*RECIP_W-1:0];
            REG_PRINCIPAL_POINT: pp_ff     <= pwdata[2*PP_W-1:0];
            REG_IMAGE_WIDTH:     width_ff  <= pwdata[SIZE_W-1:0];
            REG_IMAGE_HEIGHT:    height_ff <= pwdata[SIZE_W-1:0];
         endcase
      end
   end

   // Read-back mux
   always_comb begin
      unique case (reg_sel)
         REG_ROT_ROW0:        prdata = CSR_DATA_W'(rot_ff[0]);
         REG_ROT_ROW1:        prdata = CSR_DATA_W'(rot_ff[1]);
         REG_ROT_ROW2:        prdata = CSR_DATA_W'(rot_ff[2]);
         REG_TRANSLATION_MM:  prdata = CSR_DATA_W'(trans_ff);
         REG_FOCAL_RECIP:     prdata = CSR_DATA_W'(recip_ff);
         REG_PRINCIPAL_POINT: prdata = CSR_DATA_W'(pp_ff);
         REG_IMAGE_WIDTH:     prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT:    prdata = CSR_DATA_W'(height_ff);
      endcase
   end

   always_comb begin
      cfg.rot_row         = rot_ff;
      cfg.translation     = trans_ff;
      cfg.focal_recip     = recip_ff;
      cfg.principal_point = pp_ff;
      cfg.image_width     = width_ff;
      cfg.image_height    = height_ff;
   end

endmodule

// ===== design/dpwp_backproj.sv =====
// Five-stage back-projection: bounds check and offset from principal point,
// scale by reciprocal focal length, round to Q.16, scale by depth, round to Q.8 mm.
// Depends on dpwp_pkg for the configuration and camera point types.
module dpwp_backproj #(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dpwp_pkg::cfg_type            cfg,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [COORD_BITS-1:0]        pixel_x,
   input  logic [COORD_BITS-1:0]        pixel_y,
   input  logic [dpwp_pkg::DEPTH_W-1:0] depth_raw,
   output logic                         out_valid,
   input  logic                         out_ready,
   output dpwp_pkg::cam_point_type      out_point
);
   import dpwp_pkg::*;

   localparam int NSTG  = 5;
   localparam int CMP_W = (COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W;
   localparam int D_W   = ((COORD_BITS + 4 > PP_W) ? COORD_BITS + 4 : PP_W) + 1;
   localparam int NW    = D_W + RECIP_W;          // offset times reciprocal
   localparam int N16_W = NW - 20;                // normalized, Q.16
   localparam int PC_W  = N16_W + DEPTH_W + 1;    // times depth, Q.16 mm
   localparam int CW    = PC_W - 8;               // camera axis, Q.8 mm
   localparam logic [NW-1:0]   ROUND_N  = NW'(1) << 19;
   localparam logic [PC_W-1:0] ROUND_PC = PC_W'(1) << 7;

   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] valid_up;
   logic [NSTG-1:0] en;

   // stage 1
   logic signed [D_W-1:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [DEPTH_W-1:0]      dep1_ff;
   logic                    inb1_ff, inb1_in;
   // stage 2
   logic signed [NW-1:0]    nx_ff, nx_in, ny_ff, ny_in;
   logic [DEPTH_W-1:0]      dep2_ff;
   logic                    inb2_ff;
   // stage 3
   logic [NW-1:0]           nrx, nry;
   logic signed [N16_W-1:0] n16x_ff, n16x_in, n16y_ff, n16y_in;
   logic [DEPTH_W-1:0]      dep3_ff;
   logic                    inb3_ff;
   // stage 4
   logic signed [PC_W-1:0]  pcx_ff, pcx_in, pcy_ff, pcy_in;
   logic [DEPTH_W-1:0]      dep4_ff;
   logic                    inb4_ff;
   // stage 5
   logic [PC_W-1:0]         prx, pry;
   logic signed [CW-1:0]    camx_n, camy_n;
   cam_point_type           cam_ff, cam_in;

   // Bubble-collapsing enables: a stage moves when empty or when the next one moves
   always_comb begin
      en[NSTG-1] = !valid_ff[NSTG-1] || out_ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign valid_up = {valid_ff[NSTG-2:0], in_valid};
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (en[k]) valid_ff[k] <= valid_up[k];
         end
      end
   end

   // Stage 1: bounds and Q.4 offset from principal point
   always_comb begin
      inb1_in = (CMP_W'(pixel_x) < CMP_W'(cfg.image_width)) &&
                (CMP_W'(pixel_y) < CMP_W'(cfg.image_height));
      dx_in   = D_W'({pixel_x, 4'b0000}) - D_W'(cfg.principal_point[PP_W-1:0]);
      dy_in   = D_W'({pixel_y, 4'b0000}) - D_W'(cfg.principal_point[2*PP_W-1:PP_W]);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         dep1_ff <= depth_raw;
         inb1_ff <= inb1_in;
      end
   end

   // Stage 2: offset times reciprocal focal length, Q.36
   always_comb begin
      nx_in = dx_ff * $signed({1'b0, cfg.focal_recip[RECIP_W-1:0]});
      ny_in = dy_ff * $signed({1'b0, cfg.focal_recip[2*RECIP_W-1:RECIP_W]});
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
         dep2_ff <= dep1_ff;
         inb2_ff <= inb1_ff;
      end
   end

   // Stage 3: round half up to Q.16
   always_comb begin
      nrx     = nx_ff + ROUND_N;
      nry     = ny_ff + ROUND_N;
      n16x_in = nrx[NW-1:20];
      n16y_in = nry[NW-1:20];
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         n16x_ff <= n16x_in;
         n16y_ff <= n16y_in;
         dep3_ff <= dep2_ff;
         inb3_ff <= inb2_ff;
      end
   end

   // Stage 4: scale by depth, Q.16 mm
   always_comb begin
      pcx_in = n16x_ff * $signed({1'b0, dep3_ff});
      pcy_in = n16y_ff * $signed({1'b0, dep3_ff});
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         pcx_ff  <= pcx_in;
         pcy_ff  <= pcy_in;
         dep4_ff <= dep3_ff;
         inb4_ff <= inb3_ff;
      end
   end

   // Stage 5: round to Q.8 mm; z is depth in Q.8
   always_comb begin
      prx        = pcx_ff + ROUND_PC;
      pry        = pcy_ff + ROUND_PC;
      camx_n     = prx[PC_W-1:8];
      camy_n     = pry[PC_W-1:8];
      cam_in.x   = CAM_W'(camx_n);
      cam_in.y   = CAM_W'(camy_n);
      cam_in.z   = $signed({{(CAM_W - DEPTH_W - 8){1'b0}}, dep4_ff, 8'h00});
      cam_in.inb = inb4_ff;
   end

   always_ff @(posedge clock) begin
      if (en[4]) cam_ff <= cam_in;
   end

   assign out_valid = valid_ff[NSTG-1];
   assign out_point = cam_ff;

   // A refused beat means every stage is full and the far side is stalled
   a_full_when_refused: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> (&valid_ff) && !out_ready)
      else $error("input refused while the pipeline has room");

   // An accepted beat lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff[0])
      else $error("accepted beat lost at stage 1");

   // A stalled middle stage keeps its item and data
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] && !en[2] |=> valid_ff[2] && $stable(n16x_ff) && $stable(n16y_ff))
      else $error("stalled stage 3 dropped or changed its item");

endmodule

// ===== design/dpwp_xform.sv =====
// Three-stage rigid transform: nine rotation products, row sums plus
// translation, then rounding to mm and saturation to 32 bits (output register).
// Depends on dpwp_pkg for the configuration and camera point types.
module dpwp_xform (
   input  logic                                clock,
   input  logic                                reset,
   input  dpwp_pkg::cfg_type                   cfg,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  dpwp_pkg::cam_point_type             in_point,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [dpwp_pkg::WORLD_W-1:0] world_x,
   output logic signed [dpwp_pkg::WORLD_W-1:0] world_y,
   output logic signed [dpwp_pkg::WORLD_W-1:0] world_z,
   output logic                                point_valid
);
   import dpwp_pkg::*;

   localparam int NSTG = 3;
   localparam logic [ACC_W-1:0] ROUND_ACC = ACC_W'(1) << 23;
   localparam logic [WORLD_W-1:0] WORLD_MAX = {1'b0, {(WORLD_W-1){1'b1}}};
   localparam logic [WORLD_W-1:0] WORLD_MIN = {1'b1, {(WORLD_W-1){1'b0}}};

   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] valid_up;
   logic [NSTG-1:0] en;

   logic signed [CAM_W-1:0]       cam [3];
   logic signed [ROT_W-1:0]       rot [3][3];
   logic signed [PROD_W-1:0]      prod_ff [3][3];
   logic signed [PROD_W-1:0]      prod_in [3][3];
   logic                          inb6_ff;
   logic signed [TRANS_W-1:0]     trans [3];
   logic signed [ACC_W-1:0]       trans_ext [3];
   logic signed [ACC_W-1:0]       acc_ff [3];
   logic signed [ACC_W-1:0]       acc_in [3];
   logic                          inb7_ff;
   logic [ACC_W-1:0]              acc_rnd [3];
   logic [WIDE_W-1:0]             wide [3];
   logic [2:0][WORLD_W-1:0]       world_ff, world_in;
   logic                          pv_ff;

   // Stage enables, same scheme as the front half
   always_comb begin
      en[NSTG-1] = !valid_ff[NSTG-1] || out_ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign valid_up = {valid_ff[NSTG-2:0], in_valid};
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (en[k]) valid_ff[k] <= valid_up[k];
         end
      end
   end

   // Stage 6: rotation entry times camera component, Q.24
   always_comb begin
      cam[0] = in_point.x;
      cam[1] = in_point.y;
      cam[2] = in_point.z;
      for (int a = 0; a < 3; a++) begin
         for (int k = 0; k < 3; k++) begin
            rot[a][k]     = $signed(cfg.rot_row[a][ROT_W*k +: ROT_W]);
            prod_in[a][k] = rot[a][k] * cam[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff <= prod_in;
         inb6_ff <= in_point.inb;
      end
   end

   // Stage 7: row sum plus translation in Q.24
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         trans[a]     = $signed(cfg.translation[TRANS_W*a +: TRANS_W]);
         trans_ext[a] = ACC_W'(trans[a]);
         acc_in[a]    = ACC_W'(prod_ff[a][0]) + ACC_W'(prod_ff[a][1]) +
                        ACC_W'(prod_ff[a][2]) + (trans_ext[a] <<< 24);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         acc_ff  <= acc_in;
         inb7_ff <= inb6_ff;
      end
   end

   // Stage 8: round half up to mm, saturate; out-of-image points read as zero
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         acc_rnd[a] = acc_ff[a] + ROUND_ACC;
         wide[a]    = acc_rnd[a][ACC_W-1:24];
         if (!inb7_ff) begin
            world_in[a] = '0;
         end else if ((&wide[a][WIDE_W-1:WORLD_W-1]) || !(|wide[a][WIDE_W-1:WORLD_W-1])) begin
            world_in[a] = wide[a][WORLD_W-1:0];
         end else if (wide[a][WIDE_W-1]) begin
            world_in[a] = WORLD_MIN;
         end else begin
            world_in[a] = WORLD_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         world_ff <= world_in;
         pv_ff    <= inb7_ff;
      end
   end

   assign out_valid   = valid_ff[NSTG-1];
   assign world_x     = world_ff[0];
   assign world_y     = world_ff[1];
   assign world_z     = world_ff[2];
   assign point_valid = pv_ff;

   // A summed item moves into the output register when that stage is free
   a_sum_to_out: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && en[2] |=> out_valid)
      else $error("summed item did not reach the output register");

   // Out-of-image results carry zero coordinates
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && !point_valid |-> world_x == '0 && world_y == '0 && world_z == '0)
      else $error("out-of-image point has nonzero coordinates");

   // Back pressure only when all three stages hold items
   a_full_when_refused: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> (&valid_ff) && !out_ready)
      else $error("transform refused a beat while it had room");

endmodule

// ===== design/depth_pixel_to_world_point_top.sv =====
// Depth pixel to world point: pinhole back-projection and rigid transform.
// Pipeline: an accepted pixel passes 8 register stages, the last driving rsp_valid
// (5 back-projection, 3 transform with the output register). Throughput: one
// pixel per cycle unless rsp_ready stalls; each stage moves when empty or drained.
// Reset: synchronous; clears all stage valid bits and loads register defaults
// (identity rotation, 640 x 480, zero intrinsics/translation). Uses dpwp_* files.
module depth_pixel_to_world_point_top #(
   parameter int COORD_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   // pixel input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [COORD_BITS-1:0]               req_pixel_x,
   input  logic [COORD_BITS-1:0]               req_pixel_y,
   input  logic [dpwp_pkg::DEPTH_W-1:0]        req_depth_raw,
   // world point output
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [dpwp_pkg::WORLD_W-1:0] rsp_world_x,
   output logic signed [dpwp_pkg::WORLD_W-1:0] rsp_world_y,
   output logic signed [dpwp_pkg::WORLD_W-1:0] rsp_world_z,
   output logic                                rsp_point_valid,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dpwp_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [dpwp_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [dpwp_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import dpwp_pkg::*;

   cfg_type       cfg;
   cam_point_type cam_point;
   logic          cam_valid;
   logic          cam_ready;

   dpwp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dpwp_backproj #(
      .COORD_BITS (COORD_BITS)
   ) u_backproj (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .pixel_x   (req_pixel_x),
      .pixel_y   (req_pixel_y),
      .depth_raw (req_depth_raw),
      .out_valid (cam_valid),
      .out_ready (cam_ready),
      .out_point (cam_point)
   );

   dpwp_xform u_xform (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (cam_valid),
      .in_ready    (cam_ready),
      .in_point    (cam_point),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .world_x     (rsp_world_x),
      .world_y     (rsp_world_y),
      .world_z     (rsp_world_z),
      .point_valid (rsp_point_valid)
   );

endmodule
